// File: hdl/ascii_led_button_console_top_defines.svh
// assertion macros for the ascii led button console checker
`ifndef ASCII_LED_BUTTON_CONSOLE_TOP_DEFINES_SVH
`define ASCII_LED_BUTTON_CONSOLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ALBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ALBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/albc_pkg.sv
// types, constants and character helpers of the ascii led button console
`timescale 1ns / 1ps

package albc_pkg;

  localparam int unsigned NUM_BTNS    = 2;
  localparam int unsigned NUM_LEDS    = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned CAP_LEN     = 7;
  localparam int unsigned MSG_CNT_W   = 6;

  localparam logic [MSG_CNT_W-1:0] STATUS_LEN = 6'd33;
  localparam logic [MSG_CNT_W-1:0] BTN_LEN    = 6'd8;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_L     = 8'h4c;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_U     = 8'h55;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [1:0] button_pins;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] led_bits;
  } out_t;

  typedef enum logic {
    CMD_STATUS,
    CMD_BTN
  } cmd_kind_e;

  // one message for the back end to spell out
  typedef struct packed {
    cmd_kind_e  kind;
    logic       last;
    logic       btn_idx;
    logic       btn_val;
    logic [3:0] led;
    logic [1:0] pressed;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCAN,
    F_EVAL,
    F_STAT,
    F_BTN
  } front_state_e;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // "S:L1:a,L2:b,L3:c,L4:d,B1:e,B2:f" CR LF
  function automatic logic [7:0] status_char(input logic [MSG_CNT_W-1:0] idx,
                                             input logic [3:0] led,
                                             input logic [1:0] pr);
    logic [7:0] c;
    unique case (idx) inside
      6'd0:                                    c = CH_S;
      6'd1, 6'd4, 6'd9, 6'd14, 6'd19, 6'd24, 6'd29: c = CH_COLON;
      6'd2, 6'd7, 6'd12, 6'd17:                c = CH_L;
      6'd6, 6'd11, 6'd16, 6'd21, 6'd26:        c = CH_COMMA;
      6'd22, 6'd27:                            c = CH_B;
      6'd3, 6'd23:                             c = CH_1;
      6'd8, 6'd28:                             c = CH_2;
      6'd13:                                   c = CH_3;
      6'd18:                                   c = CH_4;
      6'd5:                                    c = CH_0 + 8'(led[0]);
      6'd10:                                   c = CH_0 + 8'(led[1]);
      6'd15:                                   c = CH_0 + 8'(led[2]);
      6'd20:                                   c = CH_0 + 8'(led[3]);
      6'd25:                                   c = CH_0 + 8'(pr[0]);
      6'd30:                                   c = CH_0 + 8'(pr[1]);
      6'd31:                                   c = CH_CR;
      6'd32:                                   c = CH_LF;
      default:                                 c = CH_LF;
    endcase
    return c;
  endfunction

  // "BTNn:v" CR LF
  function automatic logic [7:0] btn_char(input logic [2:0] idx,
                                          input logic b,
                                          input logic v);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CH_B;
      3'd1:    c = CH_T;
      3'd2:    c = CH_N;
      3'd3:    c = CH_1 + 8'(b);
      3'd4:    c = CH_COLON;
      3'd5:    c = CH_0 + 8'(v);
      3'd6:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/ascii_led_button_console_top.sv
// top level of the ascii led button console
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_data_i   (func, rx_byte, button_pins)
//   out       output     out_valid_o / out_ready_i  out_data_o  (tx_byte, last, led_bits)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i  (debounce limit in ticks)
//
// byte, carriage return or quiet tick: taken in F_IDLE; a tick with reports goes to F_BTN, one push per report
// newline ending a kept line: scan a byte per cycle in F_SCAN, then decode in F_EVAL,
//   then F_STAT when a status line is issued
// replies: a byte per cycle unless out_ready_i stalls, 33 per status line, 8 per button report
// stalls: input waits outside F_IDLE, message issue waits while the queue is full, output waits on out_ready_i
// reset: asynchronous, active low; the line store has no reset, only read below length
`timescale 1ns / 1ps

module ascii_led_button_console_top import albc_pkg::*; #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // front to queue
  logic push_valid, push_ready;
  cmd_t push_cmd;

  // queue to back
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // the debounce register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // line collection, command decode, debounce
  albc_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // decouples message issue from byte output
  albc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // message to byte stream, registered output
  albc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/albc_front.sv
// front end: line buffer, line parser, button debounce and message issue
`timescale 1ns / 1ps

module albc_front import albc_pkg::*; #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output cmd_t        push_cmd_o
);

  localparam int unsigned AW = $clog2(LINE_MAX);
  localparam int unsigned LW = $clog2(LINE_MAX + 1);

  front_state_e state_q, state_d;

  logic [7:0]    mem [LINE_MAX];
  logic [LW-1:0] len_q, scan_len_q, addr_q;
  logic          ovf_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [7:0]    rd_data_q;
  logic          found_q;
  logic [AW-1:0] beg_q, end_q;
  logic [7:0]    cap_q [CAP_LEN];
  logic [2:0]    cap_cnt_q;
  logic [3:0]    led_q;
  logic [1:0]    deb_q, prev_q, chg_q, val_q;
  logic [15:0]   st_q [NUM_BTNS];
  logic [15:0]   dbc_q;

  logic          in_acc, is_byte, is_lf, is_cr, wr_en;
  logic          sp, scan_last;
  logic [LW-1:0] n_len;
  logic          led_cmd, led_on, stat_cmd;
  logic [1:0]    led_idx;
  logic [1:0]    rd_now, acc_now;
  logic [15:0]   st_nx [NUM_BTNS];

  assign in_ready_o = (state_q == F_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_byte    = (in_data_i.func == FUNC_BYTE);
  assign is_lf      = (in_data_i.rx_byte == CH_LF);
  assign is_cr      = (in_data_i.rx_byte == CH_CR);
  assign wr_en      = in_acc && is_byte && !is_lf && !is_cr && (len_q < LW'(LINE_MAX));

  assign sp        = is_space(rd_data_q);
  assign scan_last = (LW'(rd_idx_q) == (scan_len_q - LW'(1)));

  // trimmed line length and command match
  assign n_len    = LW'(end_q) - LW'(beg_q) + LW'(1);
  assign led_cmd  = found_q && (n_len >= LW'(7)) && (cap_q[0] == CH_L) && (cap_q[1] == CH_E)
                    && (cap_q[2] == CH_D) && (cap_q[3] >= CH_1) && (cap_q[3] <= CH_4);
  assign led_idx  = cap_q[3][1:0] - 2'd1;
  assign led_on   = (n_len == LW'(7)) && (cap_q[5] == CH_O) && (cap_q[6] == CH_N);
  assign stat_cmd = found_q && (n_len == LW'(6)) && (cap_q[0] == CH_S) && (cap_q[1] == CH_T)
                    && (cap_q[2] == CH_A) && (cap_q[3] == CH_T) && (cap_q[4] == CH_U)
                    && (cap_q[5] == CH_S);

  // debounce of both buttons on a tick
  always_comb begin
    for (int i = 0; i < NUM_BTNS; i++) begin
      rd_now[i] = ~in_data_i.button_pins[i];
      if (rd_now[i] != prev_q[i]) begin
        st_nx[i] = '0;
      end else if (st_q[i] != 16'hffff) begin
        st_nx[i] = st_q[i] + 16'd1;
      end else begin
        st_nx[i] = st_q[i];
      end
      acc_now[i] = (st_nx[i] > dbc_q) && (rd_now[i] != deb_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    push_valid_o = 1'b0;
    push_cmd_o   = '{kind: CMD_STATUS, last: 1'b1, btn_idx: 1'b0, btn_val: 1'b0,
                     led: led_q, pressed: deb_q};
    unique case (state_q)
      F_IDLE: begin
        if (in_acc) begin
          if (is_byte) begin
            if (is_lf && !ovf_q && (len_q != '0)) begin
              state_d = F_SCAN;
            end
          end else if (acc_now != 2'b00) begin
            state_d = F_BTN;
          end
        end
      end
      F_SCAN: begin
        if (rd_vld_q && scan_last) begin
          state_d = F_EVAL;
        end
      end
      F_EVAL: begin
        state_d = (led_cmd || stat_cmd) ? F_STAT : F_IDLE;
      end
      F_STAT: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      F_BTN: begin
        push_valid_o       = 1'b1;
        push_cmd_o.kind    = CMD_BTN;
        push_cmd_o.btn_idx = !chg_q[0];
        push_cmd_o.btn_val = chg_q[0] ? val_q[0] : val_q[1];
        push_cmd_o.last    = chg_q[0] ? !chg_q[1] : 1'b1;
        if (push_ready_i && push_cmd_o.last) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q      <= 16'd50;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      scan_len_q <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      cap_cnt_q  <= '0;
      led_q      <= '0;
      deb_q      <= '0;
      prev_q     <= '0;
      chg_q      <= '0;
      for (int i = 0; i < NUM_BTNS; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        dbc_q <= cfg_data_i;
      end
      case (state_q)
        F_IDLE: begin
          if (in_acc) begin
            if (is_byte) begin
              if (is_lf) begin
                len_q      <= '0;
                ovf_q      <= 1'b0;
                scan_len_q <= len_q;
                addr_q     <= '0;
                rd_vld_q   <= 1'b0;
                found_q    <= 1'b0;
                cap_cnt_q  <= '0;
              end else if (!is_cr) begin
                if (len_q < LW'(LINE_MAX)) begin
                  len_q <= len_q + LW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
            end else begin
              for (int i = 0; i < NUM_BTNS; i++) begin
                st_q[i] <= st_nx[i];
              end
              prev_q <= rd_now;
              deb_q  <= (deb_q & ~acc_now) | (rd_now & acc_now);
              chg_q  <= acc_now;
            end
          end
        end
        F_SCAN: begin
          if (addr_q < scan_len_q) begin
            addr_q   <= addr_q + LW'(1);
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q) begin
            if (!sp) begin
              found_q <= 1'b1;
            end
            if ((found_q || !sp) && (cap_cnt_q < 3'(CAP_LEN))) begin
              cap_cnt_q <= cap_cnt_q + 3'd1;
            end
          end
        end
        F_EVAL: begin
          if (led_cmd) begin
            led_q[led_idx] <= led_on;
          end
        end
        F_BTN: begin
          if (push_ready_i) begin
            if (chg_q[0]) begin
              chg_q[0] <= 1'b0;
            end else begin
              chg_q[1] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // line store and scan datapath
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[len_q[AW-1:0]] <= in_data_i.rx_byte;
    end
    rd_data_q <= mem[addr_q[AW-1:0]];
    rd_idx_q  <= addr_q[AW-1:0];
    if ((state_q == F_SCAN) && rd_vld_q) begin
      if (!sp) begin
        if (!found_q) begin
          beg_q <= rd_idx_q;
        end
        end_q <= rd_idx_q;
      end
      if ((found_q || !sp) && (cap_cnt_q < 3'(CAP_LEN))) begin
        cap_q[cap_cnt_q] <= rd_data_q;
      end
    end
    if (in_acc && !is_byte) begin
      val_q <= rd_now;
    end
  end

endmodule

// File: hdl/albc_queue.sv
// short message queue between front and back ends
`timescale 1ns / 1ps

module albc_queue import albc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = ent_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/albc_back.sv
// back end: spells out one message a byte per cycle into the output register, holding while out_ready_i is low
`timescale 1ns / 1ps

module albc_back import albc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pop_valid_i,
  output logic pop_ready_o,
  input  cmd_t pop_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic                 act_q;
  cmd_t                 cmd_q;
  logic [MSG_CNT_W-1:0] cnt_q;
  logic                 out_vld_q;
  out_t                 out_q;

  logic [MSG_CNT_W-1:0] msg_len;
  logic                 end_byte, load;
  logic [7:0]           ch;

  assign msg_len     = (cmd_q.kind == CMD_STATUS) ? STATUS_LEN : BTN_LEN;
  assign end_byte    = (cnt_q == (msg_len - MSG_CNT_W'(1)));
  assign load        = act_q && (!out_vld_q || out_ready_i);
  assign pop_ready_o = !act_q;
  assign ch          = (cmd_q.kind == CMD_STATUS)
                       ? status_char(cnt_q, cmd_q.led, cmd_q.pressed)
                       : btn_char(cnt_q[2:0], cmd_q.btn_idx, cmd_q.btn_val);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (!act_q && pop_valid_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (load) begin
        cnt_q <= cnt_q + MSG_CNT_W'(1);
        if (end_byte) begin
          act_q <= 1'b0;
        end
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!act_q && pop_valid_i) begin
      cmd_q <= pop_cmd_i;
    end
    if (load) begin
      out_q.tx_byte  <= ch;
      out_q.last     <= cmd_q.last && end_byte;
      out_q.led_bits <= cmd_q.led;
    end
  end

endmodule

// File: hdl/albc_checker.sv
// port-level checker of the ascii led button console, bound to the top level
`timescale 1ns / 1ps
`include "ascii_led_button_console_top_defines.svh"

module albc_checker import albc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o,
  input logic cfg_ready_o
);

  logic       out_stall, out_last, out_mid, tx_ok;
  logic [7:0] tx;
  logic [3:0] led;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_last  = out_valid_o && out_data_o.last;
  assign out_mid   = out_valid_o && out_ready_i && !out_data_o.last;
  assign tx        = out_data_o.tx_byte;
  assign led       = out_data_o.led_bits;
  assign tx_ok     = (tx == CH_CR) || (tx == CH_LF) || ((tx >= CH_COMMA) && (tx <= CH_T));

  `ALBC_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_data_o), "output not held")
  `ALBC_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_o, "config port not ready")
  `ALBC_ASSERT_IMP(a_last_lf, out_last, tx == CH_LF, "final byte is not a line feed")
  `ALBC_ASSERT_IMP(a_char_set, out_valid_o, tx_ok, "byte outside message alphabet")
  `ALBC_ASSERT_NXT(a_led_steady, out_mid, !out_valid_o || $stable(led), "led bits changed")

endmodule

bind ascii_led_button_console_top albc_checker u_albc_checker (.*);

// File: verif/tb.sv
// testbench of the ascii led button console: self-checking run of lines, ticks, debounce
`timescale 1ns / 1ps

module tb;
  import albc_pkg::*;

  localparam int LINE_MAX      = 32;
  localparam int SETTLE_CYCLES = 64;    // longest newline scan plus margin
  localparam int HOLD_CYCLES   = 400;   // long reply-side hold-off
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 30;    // least number of input transactions per random phase

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  in_t         in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data = '0;

  bit calm = 1'b0;       // no random idling on either side while set
  int hold_cnt = 0;      // reply side held off for this many cycles
  int ready_gap = 0;
  int items_sent = 0;

  always #6 clk = ~clk;

  ascii_led_button_console_top #(
    .LINE_MAX(LINE_MAX)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data)
  );

  // console behavior and the queue of reply bytes it should send
  class console_reply_check;
    logic [15:0] dbc_limit;
    logic [7:0]  line_buf [LINE_MAX];
    int          line_len;
    bit          line_ovf;
    logic [3:0]  leds;
    logic [1:0]  pressed;
    logic [1:0]  prev_rd;
    int          stable [2];
    out_t        reply_q [$];
    int          errors;

    function new();
      dbc_limit   = 16'd50;
      line_len    = 0;
      line_ovf    = 1'b0;
      leds        = '0;
      pressed     = '0;
      prev_rd     = '0;
      stable[0]   = 0;
      stable[1]   = 0;
      errors      = 0;
    endfunction

    function void set_debounce(input logic [15:0] v);
      dbc_limit = v;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function bit blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void put_char(input logic [7:0] ch);
      out_t r;
      r.tx_byte  = ch;
      r.last     = 1'b0;
      r.led_bits = leds;
      reply_q.push_back(r);
    endfunction

    function void put_status();
      int i;
      put_char(CH_S);
      put_char(CH_COLON);
      for (i = 0; i < 4; i++) begin
        put_char(CH_L);
        put_char(CH_1 + 8'(i));
        put_char(CH_COLON);
        put_char(CH_0 + 8'(leds[i]));
        put_char(CH_COMMA);
      end
      for (i = 0; i < 2; i++) begin
        put_char(CH_B);
        put_char(CH_1 + 8'(i));
        put_char(CH_COLON);
        put_char(CH_0 + 8'(pressed[i]));
        if (i == 0) put_char(CH_COMMA);
      end
      put_char(CH_CR);
      put_char(CH_LF);
    endfunction

    // trim the stored line and act on it
    function void finish_line();
      int b;
      int e;
      int n;
      logic [7:0] d;
      b = 0;
      e = line_len;
      while (b < e && blank(line_buf[b])) b++;
      while (e > b && blank(line_buf[e-1])) e--;
      n = e - b;
      if (n >= 7 && line_buf[b] == CH_L && line_buf[b+1] == CH_E &&
          line_buf[b+2] == CH_D) begin
        d = line_buf[b+3];
        if (d >= CH_1 && d <= CH_4) begin
          leds[d - CH_1] = (n == 7) && line_buf[b+5] == CH_O && line_buf[b+6] == CH_N;
          put_status();
        end
      end else if (n == 6 && line_buf[b] == CH_S && line_buf[b+1] == CH_T &&
                   line_buf[b+2] == CH_A && line_buf[b+3] == CH_T &&
                   line_buf[b+4] == CH_U && line_buf[b+5] == CH_S) begin
        put_status();
      end
    endfunction

    function void predict_reply(input in_t it);
      int   first;
      int   i;
      logic rd;
      first = reply_q.size();
      if (it.func == FUNC_BYTE) begin
        if (it.rx_byte == CH_LF) begin
          if (!line_ovf) finish_line();
          line_len = 0;
          line_ovf = 1'b0;
        end else if (it.rx_byte != CH_CR) begin
          if (line_len < LINE_MAX) begin
            line_buf[line_len] = it.rx_byte;
            line_len++;
          end else begin
            line_ovf = 1'b1;
          end
        end
      end else begin
        for (i = 0; i < 2; i++) begin
          rd = ~it.button_pins[i];
          if (rd != prev_rd[i]) stable[i] = 0;
          else if (stable[i] < 65535) stable[i]++;
          if (stable[i] > dbc_limit && rd != pressed[i]) begin
            pressed[i] = rd;
            put_char(CH_B);
            put_char(CH_T);
            put_char(CH_N);
            put_char(CH_1 + 8'(i));
            put_char(CH_COLON);
            put_char(CH_0 + 8'(rd));
            put_char(CH_CR);
            put_char(CH_LF);
          end
          prev_rd[i] = rd;
        end
      end
      if (reply_q.size() > first) reply_q[reply_q.size()-1].last = 1'b1;
    endfunction

    function void check_reply(input out_t got);
      out_t want;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transaction tx_byte=%h last=%b led_bits=%h",
                   $time, got.tx_byte, got.last, got.led_bits);
        return;
      end
      want = reply_q.pop_front();
      if (got.tx_byte !== want.tx_byte || got.last !== want.last ||
          got.led_bits !== want.led_bits) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch expected tx_byte=%h last=%b led_bits=%h, got %h %b %h",
                   $time, want.tx_byte, want.last, want.led_bits,
                   got.tx_byte, got.last, got.led_bits);
      end
    endfunction
  endclass

  console_reply_check sb;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0b;
      3:       return 8'h0c;
      default: return CH_CR;
    endcase
  endfunction

  // reply side: ready with random gaps, plus the long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt--;
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) ready_gap = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) sb.check_reply(out_data_o);
  end

  task automatic send_item(input in_t item);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sb.predict_reply(item);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] ch);
    in_t it;
    it.func        = FUNC_BYTE;
    it.rx_byte     = ch;
    it.button_pins = 2'($urandom);
    send_item(it);
  endtask

  task automatic send_tick(input logic [1:0] pins);
    in_t it;
    it.func        = FUNC_TICK;
    it.rx_byte     = 8'($urandom);
    it.button_pins = pins;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // drop valid, let every reply drain, then give a newline scan time to finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.set_debounce(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a steady reading over a run of ticks, long enough to pass the debounce most times when the limit is at most 100
  task automatic tick_run(input int unsigned dbc);
    logic [1:0] pins;
    int len;
    pins = 2'($urandom);
    if (dbc > 100) len = $urandom_range(1, 12);
    else if ($urandom_range(0, 9) < 7) len = dbc + 2 + $urandom_range(0, 2);
    else len = $urandom_range(1, dbc + 1);
    repeat (len) send_tick(pins);
  endtask

  task automatic send_random_line();
    logic [7:0] chars [$];
    logic [7:0] c;
    int r;
    int k;
    int len;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 2)) chars.push_back(blank_char());
    if (r < 40) begin
      // led command, sometimes with a bad digit or odd text
      chars.push_back(CH_L);
      chars.push_back(CH_E);
      chars.push_back(CH_D);
      if ($urandom_range(0, 4) != 0) chars.push_back(CH_1 + 8'($urandom_range(0, 3)));
      else chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
      if ($urandom_range(0, 3) == 0) chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
      else chars.push_back(CH_COLON);
      k = $urandom_range(0, 9);
      if (k < 5) begin
        chars.push_back(CH_O);
        chars.push_back(CH_N);
      end else if (k < 7) begin
        chars.push_back(CH_O);
        chars.push_back(CH_N);
        chars.push_back(CH_N);
      end else if (k < 8) begin
        chars.push_back(CH_O);
      end else begin
        repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end
    end else if (r < 60) begin
      chars.push_back(CH_S);
      chars.push_back(CH_T);
      chars.push_back(CH_A);
      chars.push_back(CH_T);
      chars.push_back(CH_U);
      chars.push_back(CH_S);
      if ($urandom_range(0, 4) == 0)
        chars[chars.size() - 1 - $urandom_range(0, 5)] = 8'($urandom_range(8'h21, 8'h7e));
    end else if (r < 68) begin
      // blank line, padding only
    end else if (r < 80) begin
      // a command padded out around the line store size, kept or discarded
      len = $urandom_range(28, 40);
      chars.delete();
      if ($urandom_range(0, 1)) begin
        chars = '{CH_S, CH_T, CH_A, CH_T, CH_U, CH_S};
      end else begin
        chars = '{CH_L, CH_E, CH_D, CH_1, CH_COLON, CH_O, CH_N};
        chars[3] = CH_1 + 8'($urandom_range(0, 3));
      end
      while (chars.size() < len) chars.push_back(CH_SPACE);
    end else begin
      // noise bytes of any value but newline
      repeat ($urandom_range(1, 10)) begin
        c = 8'($urandom);
        if (c == CH_LF) c = 8'h0b;
        chars.push_back(c);
      end
    end
    if (r < 68 && $urandom_range(0, 1)) repeat ($urandom_range(1, 2)) chars.push_back(blank_char());
    if ($urandom_range(0, 3) == 0) chars.push_back(CH_CR);
    chars.push_back(CH_LF);
    foreach (chars[i]) send_byte(chars[i]);
  endtask

  initial begin
    logic [15:0] plan [8];
    int          first;
    int          p;
    in_t         it;

    sb = new();
    plan = '{16'd1, 16'd0, 16'd3, 16'd50, 16'd2, 16'd65535, 16'd7, 16'd0};
    plan[7] = 16'($urandom_range(0, 5));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: button press and release at zero debounce, an led command, a status request
    write_debounce(16'd0);
    send_tick(2'b11);
    send_tick(2'b10);
    send_tick(2'b10);
    send_tick(2'b00);
    send_tick(2'b00);
    send_tick(2'b11);
    send_tick(2'b11);
    send_text("LED4:ON\r\n");
    send_text("STATUS\n");

    // fill the message queue while the reply side is held off
    wait_idle();
    calm = 1'b1;
    hold_cnt = HOLD_CYCLES;
    repeat (8) send_text("STATUS\n");
    wait_idle();
    calm = 1'b0;

    // random phases, one debounce setting each
    for (p = 0; p < 8; p++) begin
      wait_idle();
      write_debounce(plan[p]);
      calm = (p == 6);
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_random_line();
          6, 7, 8:          tick_run(plan[p]);
          default: begin
            repeat ($urandom_range(1, 4)) begin
              it = in_t'($urandom);
              send_item(it);
            end
          end
        endcase
      end
    end
    calm = 1'b0;

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
